// ===== design/pidff_pkg.sv =====
// ----------------------------------------------------------------------------
// pidff_pkg: shared types and constants
// Fixed-point constants, register indexes and the divider handshake structs.
// ----------------------------------------------------------------------------
package pidff_pkg;

   localparam int FracBits = 16;
   localparam longint FxOne = longint'(1) << FracBits;
   localparam logic [17:0] K07 = 18'((7 * FxOne + 5) / 10);
   localparam logic [17:0] K03 = 18'((3 * FxOne + 5) / 10);
   localparam logic [17:0] K09 = 18'((9 * FxOne + 5) / 10);
   localparam logic [16:0] StepFloor = 17'((FxOne + 500) / 1000);

   localparam logic [2:0] REG_GAIN_P   = 3'd0;
   localparam logic [2:0] REG_GAIN_D   = 3'd1;
   localparam logic [2:0] REG_GAIN_I   = 3'd2;
   localparam logic [2:0] REG_GAIN_FF  = 3'd3;
   localparam logic [2:0] REG_RATIO    = 3'd4;
   localparam logic [2:0] REG_LIMIT    = 3'd5;

   // unsigned divider: 64-bit dividend, 32-bit divisor
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/pid_feedforward_controller.sv =====
// ----------------------------------------------------------------------------
// pid_feedforward_controller: PID position controller with feedforward
// Q16.16 control step with filtered target velocity and gated integrator.
// ----------------------------------------------------------------------------
//  channel  ports                      direction
//  req      req_valid/ready + 4 fields  in
//  rsp      rsp_valid/ready, rsp_drive  out
//  csr      csr_valid/ready, index/data in
//
// A word passes through the IDLE accept state, three divides (integral limit,
// velocity, threshold) in the shared divider, eight multiply steps on one
// shared 33x33 multiplier, SAT and DONE. req_ready is high only in IDLE. The
// drive word sits in a register until taken; a stalled rsp holds the sequencer
// in DONE. Reset is synchronous and clears the state, the CSR registers, the
// last target, the filtered velocity and the integrator.
module pid_feedforward_controller import pidff_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_measured_velocity,
   input  logic signed [31:0] req_target_position,
   input  logic        [16:0] req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_M0    = 11'b00000000010, // ratio*limit -> div
      S_D0    = 11'b00000000100, // wait ilimit; start vel div
      S_D1    = 11'b00000001000, // wait raw; start thresh div
      S_D2    = 11'b00000010000, // wait thresh
      S_F0    = 11'b00000100000, // filter products
      S_F1    = 11'b00001000000,
      S_INT   = 11'b00010000000, // integrate or decay
      S_OUT   = 11'b00100000000, // four output products
      S_SAT   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [30:0] kp_ff, kd_ff, ki_ff, kff_ff, lim_ff;
   logic [16:0] ratio_ff;
   logic signed [31:0] last_ff, tve_ff, integ_ff;
   logic signed [31:0] pos_ff, vel_ff, tgt_ff;
   logic [16:0] dt_ff;
   logic signed [32:0] err_ff;
   logic [31:0] ilim_ff;
   logic [32:0] thr_ff;
   logic signed [31:0] raw_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic [1:0] sub_ff, sub_in;
   logic signed [31:0] drive_ff, drive_in;
   logic [31:0] ilim_in;
   logic [32:0] thr_in;
   logic signed [31:0] raw_in, tve_in, integ_in, last_in;
   logic signed [32:0] err_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   pidff_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // shared multiplier
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic signed [65:0] mul_q; // truncated toward zero >> FracBits
   assign mul_p = mul_a * mul_b;
   assign mul_q = (mul_p + (mul_p[65] ? 66'sd65535 : 66'sd0)) >>> FracBits;

   // signed dividend helpers
   logic signed [33:0] dtgt;
   logic        [33:0] dtgt_abs;
   logic        [16:0] dt_fl;
   logic        [30:0] kp_fl, ki_fl;
   logic        [63:0] q_abs;
   logic signed [65:0] q_s;
   assign dtgt     = 34'(tgt_ff) - 34'(last_ff);
   assign dtgt_abs = dtgt[33] ? 34'(-dtgt) : dtgt;
   assign dt_fl    = (dt_ff < StepFloor) ? StepFloor : dt_ff;
   assign kp_fl    = (kp_ff < 31'(StepFloor)) ? 31'(StepFloor) : kp_ff;
   assign ki_fl    = (ki_ff == '0) ? 31'd1 : ki_ff;
   assign q_abs    = div_rsp.quotient;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   logic signed [33:0] sum_ie;
   logic signed [33:0] lim_s;
   assign lim_s  = 34'(lim_ff);
   assign sum_ie = 34'(integ_ff) + 34'(err_ff);

   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      acc_in   = acc_ff;
      ilim_in  = ilim_ff;
      thr_in   = thr_ff;
      raw_in   = raw_ff;
      tve_in   = tve_ff;
      integ_in = integ_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      drive_in = drive_ff;
      div_req  = '0;
      mul_a    = '0;
      mul_b    = '0;
      q_s      = dtgt[33] ? -$signed({2'b0, q_abs}) : $signed({2'b0, q_abs});
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_M0;
            end
         end
         S_M0: begin
            mul_a = $signed({16'b0, ratio_ff});
            mul_b = $signed({2'b0, lim_ff});
            div_req.start    = 1'b1;
            div_req.dividend = mul_p[63:0];
            div_req.divisor  = {1'b0, ki_fl};
            err_in   = 33'(tgt_ff) - 33'(pos_ff);
            state_in = S_D0;
         end
         S_D0: begin
            if (div_rsp.done) begin
               ilim_in = (q_abs > 64'h7fffffff) ? 32'h7fffffff : q_abs[31:0];
               div_req.start    = 1'b1;
               div_req.dividend = {14'b0, dtgt_abs, 16'b0};
               div_req.divisor  = {15'b0, dt_fl};
               state_in = S_D1;
            end
         end
         S_D1: begin
            if (div_rsp.done) begin
               raw_in = sat32(q_s);
               div_req.start    = 1'b1;
               div_req.dividend = {17'b0, lim_ff, 16'b0};
               div_req.divisor  = {1'b0, kp_fl};
               state_in = S_D2;
            end
         end
         S_D2: begin
            if (div_rsp.done) begin
               thr_in   = (q_abs > 64'hffffffff) ? 33'h1_0000_0000 : {1'b0, q_abs[31:0]};
               state_in = S_F0;
            end
         end
         S_F0: begin
            mul_a    = $signed({15'b0, K07});
            mul_b    = 33'(tve_ff);
            acc_in   = mul_q;
            state_in = S_F1;
         end
         S_F1: begin
            mul_a    = $signed({15'b0, K03});
            mul_b    = 33'(raw_ff);
            tve_in   = sat32(acc_ff + mul_q);
            state_in = S_INT;
         end
         S_INT: begin
            mul_a = $signed({15'b0, K09});
            mul_b = 33'(integ_ff);
            if ((err_ff[32] ? -34'(err_ff) : 34'(err_ff)) < $signed({1'b0, thr_ff})) begin
               if (sum_ie > $signed({2'b0, ilim_ff})) begin
                  integ_in = ilim_ff;
               end else if (sum_ie < -$signed({2'b0, ilim_ff})) begin
                  integ_in = -ilim_ff;
               end else begin
                  integ_in = sum_ie[31:0];
               end
            end else begin
               integ_in = mul_q[31:0];
            end
            acc_in   = '0;
            sub_in   = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            case (sub_ff)
               2'd0: begin
                  mul_a = $signed({2'b0, kp_ff});
                  mul_b = err_ff;
               end
               2'd1: begin
                  mul_a = $signed({2'b0, ki_ff});
                  mul_b = 33'(integ_ff);
               end
               2'd2: begin
                  mul_a = -$signed({2'b0, kd_ff});
                  mul_b = 33'(vel_ff);
               end
               default: begin
                  mul_a = $signed({2'b0, kff_ff});
                  mul_b = 33'(tve_ff);
               end
            endcase
            acc_in = acc_ff + mul_q;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd3) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (acc_ff > 66'(lim_s)) begin
               drive_in = {1'b0, lim_ff};
            end else if (acc_ff < -66'(lim_s)) begin
               drive_in = -$signed({1'b0, lim_ff});
            end else begin
               drive_in = acc_ff[31:0];
            end
            last_in  = tgt_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kp_ff    <= '0;
         kd_ff    <= '0;
         ki_ff    <= '0;
         kff_ff   <= '0;
         ratio_ff <= '0;
         lim_ff   <= '0;
         last_ff  <= '0;
         tve_ff   <= '0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         tve_ff   <= tve_in;
         integ_ff <= integ_in;
         if (csr_valid) begin
            case (csr_index)
               REG_GAIN_P:  kp_ff    <= csr_data[30:0];
               REG_GAIN_D:  kd_ff    <= csr_data[30:0];
               REG_GAIN_I:  ki_ff    <= csr_data[30:0];
               REG_GAIN_FF: kff_ff   <= csr_data[30:0];
               REG_RATIO:   ratio_ff <= csr_data[16:0];
               REG_LIMIT:   lim_ff   <= csr_data[30:0];
               default: ;
            endcase
         end
      end
      if (state_ff == S_IDLE && req_valid) begin
         pos_ff <= req_measured_position;
         vel_ff <= req_measured_velocity;
         tgt_ff <= req_target_position;
         dt_ff  <= req_time_step;
      end
      sub_ff   <= sub_in;
      acc_ff   <= acc_in;
      ilim_ff  <= ilim_in;
      thr_ff   <= thr_in;
      raw_ff   <= raw_in;
      err_ff   <= err_in;
      drive_ff <= drive_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_drive = drive_ff;
   assign csr_ready = 1'b1;

   property p_one_state;
      @(posedge clock) disable iff (reset) $onehot(state_ff);
   endproperty
   a_one_state: assert property (p_one_state) else $error("state not one-hot");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("drive word dropped");

   property p_drive_bound;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_drive <= $signed({1'b0, lim_ff}) &&
                        rsp_drive >= -$signed({1'b0, lim_ff}));
   endproperty
   a_drive_bound: assert property (p_drive_bound) else $error("drive beyond limit");

endmodule

// ===== design/pidff_div.sv =====
// ----------------------------------------------------------------------------
// pidff_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; a new start restarts the divide.
// ----------------------------------------------------------------------------
module pidff_div import pidff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quot_ff[63]};
      diff    = {1'b0, trial} - {2'b0, dsr_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in  = diff[32:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   property p_done_idle;
      @(posedge clock) disable iff (reset) done_ff |-> !busy_ff;
   endproperty
   a_done_idle: assert property (p_done_idle) else $error("divider busy while done");

   property p_done_after_last;
      @(posedge clock) disable iff (reset)
         (busy_ff && cnt_ff == 7'd63 && !div_req.start) |=> done_ff;
   endproperty
   a_done_after_last: assert property (p_done_after_last)
      else $error("divider did not finish");

   property p_start_busy;
      @(posedge clock) disable iff (reset) div_req.start |=> busy_ff;
   endproperty
   a_start_busy: assert property (p_start_busy) else $error("divider not started");

   property p_cnt_reset;
      @(posedge clock) disable iff (reset) div_req.start |=> cnt_ff == 7'd0;
   endproperty
   a_cnt_reset: assert property (p_cnt_reset) else $error("divider count not cleared");

endmodule
